// ===== sv/u8d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CP_WIDTH = 21;
    localparam int LIMIT_WIDTH = 16;
    localparam int REPORT_WIDTH = 16;
    localparam int ADDR_WIDTH = 3;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [REPORT_WIDTH-1:0] REPORT_MAX = 16'hFFFF;

    localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b0;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] CODE_CONT = 8'h80;
    localparam logic [7:0] BITS_LEAD2 = 8'h1F;
    localparam logic [7:0] BITS_LEAD3 = 8'h0F;
    localparam logic [7:0] BITS_LEAD4 = 8'h07;
    localparam logic [7:0] BITS_CONT = 8'h3F;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    typedef struct packed {
        logic                    has_codepoint;
        logic [CP_WIDTH-1:0]     codepoint;
        logic                    message_end;
        logic [REPORT_WIDTH-1:0] bytes_consumed;
        logic [REPORT_WIDTH-1:0] codepoints_made;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/u8d_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode #(
    parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_take,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              last_byte,
    input  wire logic [u8d_pkg::LIMIT_WIDTH-1:0]   output_limit,
    output u8d_pkg::result_t                       res,
    output logic                                   res_push
);

    localparam int RW = (COUNT_WIDTH > u8d_pkg::LIMIT_WIDTH) ? COUNT_WIDTH
                                                              : u8d_pkg::LIMIT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]                   bytes_remaining_reg, bytes_remaining_next;
    logic [u8d_pkg::CP_WIDTH-1:0] accumulator_reg, accumulator_next;
    logic                         sequence_bad_reg, sequence_bad_next;
    logic [COUNT_WIDTH-1:0]       consumed_count_reg, consumed_count_next;
    logic [COUNT_WIDTH-1:0]       produced_count_reg, produced_count_next;
    logic                         limit_reached_reg, limit_reached_next;

    logic                         have;
    logic [u8d_pkg::CP_WIDTH-1:0] cp;
    logic                         consume;
    logic [RW-1:0]                prod_ext;
    logic [RW-1:0]                cons_rep;
    logic [RW-1:0]                prod_rep;

    assign prod_ext = RW'(produced_count_reg);

    always_comb begin
        bytes_remaining_next = bytes_remaining_reg;
        accumulator_next     = accumulator_reg;
        sequence_bad_next    = sequence_bad_reg;
        limit_reached_next   = limit_reached_reg;
        have                 = 1'b0;
        cp                   = '0;
        consume              = 1'b0;

        if (bytes_remaining_reg == 2'd0) begin
            if (!limit_reached_reg && (prod_ext < RW'(output_limit))) begin
                consume = 1'b1;
                if (data_byte < u8d_pkg::ASCII_LIMIT) begin
                    have = 1'b1;
                    cp   = u8d_pkg::CP_WIDTH'(data_byte);
                end else if ((data_byte & u8d_pkg::MASK_LEAD2) == u8d_pkg::CODE_LEAD2) begin
                    bytes_remaining_next = 2'd1;
                    accumulator_next     = u8d_pkg::CP_WIDTH'(data_byte & u8d_pkg::BITS_LEAD2);
                    sequence_bad_next    = 1'b0;
                end else if ((data_byte & u8d_pkg::MASK_LEAD3) == u8d_pkg::CODE_LEAD3) begin
                    bytes_remaining_next = 2'd2;
                    accumulator_next     = u8d_pkg::CP_WIDTH'(data_byte & u8d_pkg::BITS_LEAD3);
                    sequence_bad_next    = 1'b0;
                end else if ((data_byte & u8d_pkg::MASK_LEAD4) == u8d_pkg::CODE_LEAD4) begin
                    bytes_remaining_next = 2'd3;
                    accumulator_next     = u8d_pkg::CP_WIDTH'(data_byte & u8d_pkg::BITS_LEAD4);
                    sequence_bad_next    = 1'b0;
                end else begin
                    have = 1'b1;
                    cp   = u8d_pkg::REPLACEMENT_CP;
                end
            end else begin
                limit_reached_next = 1'b1;
            end
        end else begin
            consume = 1'b1;
            if ((data_byte & u8d_pkg::MASK_CONT) != u8d_pkg::CODE_CONT) begin
                sequence_bad_next = 1'b1;
            end else begin
                accumulator_next = {accumulator_reg[u8d_pkg::CP_WIDTH-7:0],
                                    data_byte[5:0] & u8d_pkg::BITS_CONT[5:0]};
            end
            bytes_remaining_next = bytes_remaining_reg - 2'd1;
            if (bytes_remaining_next == 2'd0) begin
                have = 1'b1;
                cp   = sequence_bad_next ? u8d_pkg::REPLACEMENT_CP : accumulator_next;
            end
        end

        // sequence cut short by message end
        if (last_byte && (bytes_remaining_next != 2'd0)) begin
            have                 = 1'b1;
            cp                   = u8d_pkg::REPLACEMENT_CP;
            bytes_remaining_next = 2'd0;
        end

        consumed_count_next = consumed_count_reg;
        if (consume && (consumed_count_reg != CNT_MAX)) begin
            consumed_count_next = consumed_count_reg + COUNT_WIDTH'(1);
        end
        produced_count_next = produced_count_reg;
        if (have && (produced_count_reg != CNT_MAX)) begin
            produced_count_next = produced_count_reg + COUNT_WIDTH'(1);
        end
    end

    assign cons_rep = RW'(consumed_count_next);
    assign prod_rep = RW'(produced_count_next);

    always_comb begin
        res.has_codepoint   = have;
        res.codepoint       = have ? cp : '0;
        res.message_end     = last_byte;
        res.bytes_consumed  = '0;
        res.codepoints_made = '0;
        if (last_byte) begin
            res.bytes_consumed  = (cons_rep > RW'(u8d_pkg::REPORT_MAX))
                                  ? u8d_pkg::REPORT_MAX : cons_rep[u8d_pkg::REPORT_WIDTH-1:0];
            res.codepoints_made = (prod_rep > RW'(u8d_pkg::REPORT_MAX))
                                  ? u8d_pkg::REPORT_MAX : prod_rep[u8d_pkg::REPORT_WIDTH-1:0];
        end
    end

    assign res_push = in_take && (have || last_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_remaining_reg <= '0;
            accumulator_reg     <= '0;
            sequence_bad_reg    <= 1'b0;
            consumed_count_reg  <= '0;
            produced_count_reg  <= '0;
            limit_reached_reg   <= 1'b0;
        end else if (in_take) begin
            if (last_byte) begin
                bytes_remaining_reg <= '0;
                accumulator_reg     <= '0;
                sequence_bad_reg    <= 1'b0;
                consumed_count_reg  <= '0;
                produced_count_reg  <= '0;
                limit_reached_reg   <= 1'b0;
            end else begin
                bytes_remaining_reg <= bytes_remaining_next;
                accumulator_reg     <= accumulator_next;
                sequence_bad_reg    <= sequence_bad_next;
                consumed_count_reg  <= consumed_count_next;
                produced_count_reg  <= produced_count_next;
                limit_reached_reg   <= limit_reached_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/u8d_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  u8d_pkg::result_t      push_data,
    output logic                  can_take,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output u8d_pkg::result_t      out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    u8d_pkg::result_t main_data_reg, main_data_next;
    u8d_pkg::result_t skid_data_reg, skid_data_next;

    assign can_take  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !main_valid_reg) begin
            main_valid_next = skid_valid_reg || push;
            main_data_next  = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end else if (push) begin
            // main stalled, park the new item
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== sv/utf8_to_codepoint_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_data_byte[7:0], s_last_byte
// m_        out        m_valid / m_ready  m_has_codepoint, m_codepoint[20:0], m_message_end,
//                                         m_bytes_consumed[15:0], m_codepoints_made[15:0]
// apb       in         psel / penable     paddr[2:0], pwdata[31:0] -> output_limit
//
// one byte per cycle while s_ready is high; a result is registered in the skid buffer before it shows on m_
// decode state is updated by the byte decoder, results sit in a two-entry skid buffer
// s_ready drops only while both buffer entries are full under m_ stall
// aresetn is synchronous: clears decode state, empties the buffer, output_limit to 65535

module utf8_to_codepoint_decoder_top #(
    parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_data_byte,
    input  wire logic                                s_last_byte,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_has_codepoint,
    output logic [u8d_pkg::CP_WIDTH-1:0]             m_codepoint,
    output logic                                     m_message_end,
    output logic [u8d_pkg::REPORT_WIDTH-1:0]         m_bytes_consumed,
    output logic [u8d_pkg::REPORT_WIDTH-1:0]         m_codepoints_made,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [u8d_pkg::ADDR_WIDTH-1:0]      paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    logic [u8d_pkg::LIMIT_WIDTH-1:0] output_limit_reg;
    logic                            in_take;
    logic                            push;
    logic                            can_take;
    u8d_pkg::result_t                dec_res;
    u8d_pkg::result_t                out_res;
    logic                            reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == u8d_pkg::REG_OUTPUT_LIMIT);
    assign prdata  = reg_sel ? 32'(output_limit_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_limit_reg <= u8d_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            output_limit_reg <= pwdata[u8d_pkg::LIMIT_WIDTH-1:0];
        end
    end

    assign s_ready = can_take;
    assign in_take = s_valid && can_take;

    u8d_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_take      (in_take),
        .data_byte    (s_data_byte),
        .last_byte    (s_last_byte),
        .output_limit (output_limit_reg),
        .res          (dec_res),
        .res_push     (push)
    );

    u8d_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (dec_res),
        .can_take  (can_take),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_has_codepoint   = out_res.has_codepoint;
    assign m_codepoint       = out_res.codepoint;
    assign m_message_end     = out_res.message_end;
    assign m_bytes_consumed  = out_res.bytes_consumed;
    assign m_codepoints_made = out_res.codepoints_made;

endmodule

`default_nettype wire

// ===== sv/u8d_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8d_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_has_codepoint,
    input wire logic [20:0] m_codepoint,
    input wire logic        m_message_end,
    input wire logic [15:0] m_bytes_consumed,
    input wire logic [15:0] m_codepoints_made
);

    // stalled result item holds valid, codepoint, message end and bytes consumed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_codepoint)
            && $stable(m_message_end) && $stable(m_bytes_consumed))
        else $error("stalled result item changed");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_codepoint |-> m_codepoint == 21'd0)
        else $error("codepoint without flag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_message_end |-> m_bytes_consumed == 16'd0
            && m_codepoints_made == 16'd0)
        else $error("counts outside message end");

    // every codepoint needs at least one consumed byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_end |-> m_codepoints_made <= m_bytes_consumed)
        else $error("more codepoints than bytes");

endmodule

bind utf8_to_codepoint_decoder_top u8d_checker u_u8d_checker (.*);

`default_nettype wire
